FILE: sv/safety_watchdog_estop_fsm_assert.svh
// ----------------------------------------------------------------------------
// safety_watchdog_estop_fsm_assert.svh
// Assertion macros shared by the watchdog / emergency-stop controller.
// ----------------------------------------------------------------------------
`ifndef SAFETY_WATCHDOG_ESTOP_FSM_ASSERT_SVH
`define SAFETY_WATCHDOG_ESTOP_FSM_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SWE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swe assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SWE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swe assertion failed");

`endif

FILE: sv/swe_pkg.sv
// ----------------------------------------------------------------------------
// swe_pkg
// Types and codes of the watchdog / emergency-stop controller.
// ----------------------------------------------------------------------------
`default_nettype none

package swe_pkg;

    localparam int unsigned MODE_W = 4;
    localparam int unsigned BL_W   = 2;

    // Controller modes
    localparam logic [MODE_W-1:0] MODE_STARTUP   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_LOCAL     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_LPUSHED   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_REMOTE    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_WSTOP     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_WRELAYOFF = 4'd5;
    localparam logic [MODE_W-1:0] MODE_PCWAIT    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_RSTOP     = 4'd7;
    localparam logic [MODE_W-1:0] MODE_RRELAYOFF = 4'd8;
    localparam logic [MODE_W-1:0] MODE_RSTOPPED  = 4'd9;

    // Button light modes
    localparam logic [BL_W-1:0] BL_OFF   = 2'd0;
    localparam logic [BL_W-1:0] BL_ON    = 2'd1;
    localparam logic [BL_W-1:0] BL_FLASH = 2'd2;
    localparam logic [BL_W-1:0] BL_FAST  = 2'd3;

    typedef struct packed {
        logic wd_msg_seen;
        logic button_pushed;
        logic wd_expired;
        logic trains_running;
        logic halt_wait_expired;
        logic pc_wait_expired;
    } tick_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              relay_closed;
        logic              yellow_lamp;
        logic              green_lamp;
        logic              red_lamp;
        logic [BL_W-1:0]   button_light;
        logic              emergency_flag;
        logic              start_halt_timer;
        logic              start_pc_timer;
        logic              clear_moving;
        logic              mode_changed;
    } result_t;

    // Held controller state
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              relay;
        logic              yellow;
        logic              green;
        logic              red;
        logic [BL_W-1:0]   light;
        logic              emerg;
    } ctl_state_t;

    // One-tick pulses from a transition
    typedef struct packed {
        logic halt_timer;
        logic pc_timer;
        logic clear_moving;
    } pulse_t;

endpackage

`default_nettype wire

FILE: sv/swe_chan_if.sv
// ----------------------------------------------------------------------------
// swe_tick_if / swe_result_if
// Valid/ready channels for ticks and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface swe_tick_if;
    logic          valid;
    logic          ready;
    swe_pkg::tick_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface swe_result_if;
    logic            valid;
    logic            ready;
    swe_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/safety_watchdog_estop_fsm.sv
// ----------------------------------------------------------------------------
// safety_watchdog_estop_fsm
// Watchdog and emergency-stop controller, stepped once per tick transaction.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one transaction per controller tick, carrying the event flags
//            (watchdog message, button press, timer expiries, trains moving).
//   result : one transaction per tick with the mode after the step, the held
//            relay / lamp / button-light / emergency levels, the one-tick
//            timer and clear pulses, and a mode-changed flag.
//   A tick lands in the input register, then the mode decision runs and loads
//   the result register. Throughput is one tick per cycle while the receiver
//   keeps taking results; the limit is the combinational decision against the
//   held state register.
//   Reset puts the controller in startup with relay released, all lamps and
//   the button light off and the emergency flag clear; both stages empty.
//   When the receiver stalls, the result register holds, one more tick waits
//   in the input register, and tick.ready then drops until result moves.
// ----------------------------------------------------------------------------
`default_nettype none

module safety_watchdog_estop_fsm (
    input  wire           clk,
    input  wire           rst_n,
    swe_tick_if.sink      tick,
    swe_result_if.source  result
);
    import swe_pkg::*;

    `include "safety_watchdog_estop_fsm_assert.svh"

    logic       in_valid_reg;
    tick_t      in_data_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    ctl_state_t state_reg;

    ctl_state_t state_next;
    pulse_t     pulse;
    logic       advance;
    logic       step;

    swe_step u_step (
        .cur   (state_reg),
        .tick  (in_data_reg),
        .nxt   (state_next),
        .pulse (pulse)
    );

    // advance when the result slot is empty or being drained
    assign advance     = !out_valid_reg || result.ready;
    assign step        = in_valid_reg && advance;
    assign tick.ready  = !in_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: MODE_STARTUP, light: BL_OFF, default: 1'b0};
        end
        else
        begin
            if (tick.ready)
            begin
                in_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_data_reg <= tick.data;
        end
        if (step)
        begin
            out_data_reg.mode             <= state_next.mode;
            out_data_reg.relay_closed     <= state_next.relay;
            out_data_reg.yellow_lamp      <= state_next.yellow;
            out_data_reg.green_lamp       <= state_next.green;
            out_data_reg.red_lamp         <= state_next.red;
            out_data_reg.button_light     <= state_next.light;
            out_data_reg.emergency_flag   <= state_next.emerg;
            out_data_reg.start_halt_timer <= pulse.halt_timer;
            out_data_reg.start_pc_timer   <= pulse.pc_timer;
            out_data_reg.clear_moving     <= pulse.clear_moving;
            out_data_reg.mode_changed     <= (state_next.mode != state_reg.mode);
        end
    end

    // held mode always matches the mode last reported
    `SWE_ASSERT_NEXT(a_mode_tracks, step, state_reg.mode == out_data_reg.mode)

    // a stalled input means both stages are occupied
    `SWE_ASSERT_NOW(a_stall_full, !tick.ready, in_valid_reg && out_valid_reg)

    // halt timer start comes with clear-moving and the red lamp
    `SWE_ASSERT_NOW(a_halt_pulse, out_valid_reg && out_data_reg.start_halt_timer,
        out_data_reg.clear_moving && out_data_reg.red_lamp)

    // PC timer start only on entry to the PC wait mode with the emergency flag set
    `SWE_ASSERT_NOW(a_pc_pulse, out_valid_reg && out_data_reg.start_pc_timer,
        out_data_reg.mode == MODE_PCWAIT && out_data_reg.emergency_flag
        && out_data_reg.mode_changed)

    // relay is released whenever a relay-off or local pushed mode is reported
    `SWE_ASSERT_NOW(a_relay_off, out_valid_reg && (out_data_reg.mode == MODE_LPUSHED
        || out_data_reg.mode == MODE_WRELAYOFF || out_data_reg.mode == MODE_RRELAYOFF),
        !out_data_reg.relay_closed)

endmodule

`default_nettype wire

FILE: sv/swe_step.sv
// ----------------------------------------------------------------------------
// swe_step
// Next-state decision: one transition of the ten-mode controller per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module swe_step (
    input  swe_pkg::ctl_state_t cur,
    input  swe_pkg::tick_t      tick,
    output swe_pkg::ctl_state_t nxt,
    output swe_pkg::pulse_t     pulse
);
    import swe_pkg::*;

    always_comb
    begin
        nxt   = cur;
        pulse = '0;
        case (cur.mode)
            MODE_STARTUP:
            begin
                nxt.yellow = 1'b1;
                nxt.green  = 1'b0;
                nxt.red    = 1'b0;
                nxt.light  = BL_ON;
                nxt.relay  = 1'b1;
                nxt.emerg  = 1'b0;
                nxt.mode   = MODE_LOCAL;
            end
            MODE_LOCAL:
            begin
                if (tick.wd_msg_seen)
                begin
                    nxt.yellow = 1'b0;
                    nxt.green  = 1'b1;
                    nxt.mode   = MODE_REMOTE;
                end
                else if (tick.button_pushed)
                begin
                    // release relay, red lamp keeps its level
                    nxt.relay = 1'b0;
                    nxt.light = BL_FLASH;
                    nxt.emerg = 1'b1;
                    nxt.mode  = MODE_LPUSHED;
                end
            end
            MODE_LPUSHED, MODE_WRELAYOFF, MODE_RRELAYOFF:
            begin
                if (tick.button_pushed)
                begin
                    nxt.mode = MODE_STARTUP;
                end
            end
            MODE_REMOTE:
            begin
                if (tick.wd_msg_seen)
                begin
                    nxt.mode = MODE_REMOTE;
                end
                else if (tick.wd_expired)
                begin
                    nxt.green          = 1'b0;
                    nxt.red            = 1'b1;
                    pulse.halt_timer   = 1'b1;
                    pulse.clear_moving = 1'b1;
                    nxt.mode           = MODE_WSTOP;
                end
                else if (tick.button_pushed)
                begin
                    nxt.light      = BL_FLASH;
                    nxt.emerg      = 1'b1;
                    pulse.pc_timer = 1'b1;
                    nxt.mode       = MODE_PCWAIT;
                end
            end
            MODE_WSTOP:
            begin
                if (tick.trains_running)
                begin
                    nxt.relay = 1'b0;
                    nxt.light = BL_FAST;
                    nxt.mode  = MODE_WRELAYOFF;
                end
                else if (tick.halt_wait_expired)
                begin
                    nxt.mode = MODE_STARTUP;
                end
            end
            MODE_RSTOP:
            begin
                if (tick.trains_running)
                begin
                    nxt.relay = 1'b0;
                    nxt.light = BL_FAST;
                    nxt.mode  = MODE_RRELAYOFF;
                end
                else if (tick.halt_wait_expired)
                begin
                    nxt.mode = MODE_RSTOPPED;
                end
            end
            MODE_PCWAIT:
            begin
                if (tick.pc_wait_expired)
                begin
                    nxt.green          = 1'b0;
                    nxt.red            = 1'b1;
                    pulse.halt_timer   = 1'b1;
                    pulse.clear_moving = 1'b1;
                    nxt.mode           = MODE_RSTOP;
                end
            end
            MODE_RSTOPPED:
            begin
                if (tick.button_pushed || tick.trains_running)
                begin
                    nxt.mode = MODE_STARTUP;
                end
            end
            default:
            begin
                nxt   = cur;
                pulse = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: verif/safety_watchdog_estop_fsm_tb.sv
// ----------------------------------------------------------------------------
// safety_watchdog_estop_fsm_tb
// Drives tick transactions into the watchdog / emergency-stop controller and
// checks every result transaction against a cycle-free model of the mode
// machine or a hand-typed expectation. A directed walk covers each path of the machine, then random ticks
// follow under random gaps and stalls, a calm stretch and a long result stall.
// ----------------------------------------------------------------------------
module safety_watchdog_estop_fsm_tb;

    import swe_pkg::*;

    // Expectation typed in by hand, used instead of the model when set
    typedef struct packed {
        logic    typed;
        result_t want;
    } preset_t;

    typedef struct packed {
        tick_t   tk;
        preset_t preset;
    } dir_row_t;

    localparam preset_t NO_PRESET = '{typed: 1'b0, want: '0};

    // Startup always lands in local with the relay on and the button lit
    localparam result_t LOCAL_ENTRY = '{
        mode: MODE_LOCAL, relay_closed: 1'b1, yellow_lamp: 1'b1, green_lamp: 1'b0,
        red_lamp: 1'b0, button_light: BL_ON, emergency_flag: 1'b0,
        start_halt_timer: 1'b0, start_pc_timer: 1'b0, clear_moving: 1'b0,
        mode_changed: 1'b1};

    // Button in local: relay released, red lamp left alone
    localparam result_t LPUSHED_ENTRY = '{
        mode: MODE_LPUSHED, relay_closed: 1'b0, yellow_lamp: 1'b1, green_lamp: 1'b0,
        red_lamp: 1'b0, button_light: BL_FLASH, emergency_flag: 1'b1,
        start_halt_timer: 1'b0, start_pc_timer: 1'b0, clear_moving: 1'b0,
        mode_changed: 1'b1};

    // Watchdog expiry in remote: red on, halt timer and clear pulses
    localparam result_t WSTOP_ENTRY = '{
        mode: MODE_WSTOP, relay_closed: 1'b1, yellow_lamp: 1'b0, green_lamp: 1'b0,
        red_lamp: 1'b1, button_light: BL_ON, emergency_flag: 1'b0,
        start_halt_timer: 1'b1, start_pc_timer: 1'b0, clear_moving: 1'b1,
        mode_changed: 1'b1};

    localparam int DIR_ROWS = 27;

    // Tick bits: {wd_msg, button, wd_expired, moving, halt_expired, pc_expired}
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{6'b000000, '{1'b1, LOCAL_ENTRY}},     // startup to local
        '{6'b010000, '{1'b1, LPUSHED_ENTRY}},   // button in local
        '{6'b001111, NO_PRESET},                // lpushed ignores all but button
        '{6'b010000, NO_PRESET},
        '{6'b111111, '{1'b1, LOCAL_ENTRY}},     // startup ignores every flag
        '{6'b110000, NO_PRESET},                // message beats button
        '{6'b111111, NO_PRESET},                // message keeps remote
        '{6'b011000, '{1'b1, WSTOP_ENTRY}},     // expiry beats button
        '{6'b000110, NO_PRESET},                // moving beats halt expiry
        '{6'b010000, NO_PRESET},
        '{6'b000000, NO_PRESET},
        '{6'b100000, NO_PRESET},
        '{6'b001000, NO_PRESET},
        '{6'b000010, NO_PRESET},                // trains halted in time
        '{6'b000000, NO_PRESET},
        '{6'b100000, NO_PRESET},
        '{6'b010000, NO_PRESET},                // remote button to pc wait
        '{6'b111110, NO_PRESET},                // pc wait waits on its timer only
        '{6'b000001, NO_PRESET},
        '{6'b000110, NO_PRESET},
        '{6'b010000, NO_PRESET},
        '{6'b000000, NO_PRESET},
        '{6'b100000, NO_PRESET},
        '{6'b010000, NO_PRESET},
        '{6'b000001, NO_PRESET},
        '{6'b000010, NO_PRESET},                // remote stop completed
        '{6'b000100, NO_PRESET}
    };

    localparam int RANDOM_PHASES    = 9;
    localparam int TICKS_PER_PHASE  = 95;
    localparam int LONG_HOLD_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n;

    swe_tick_if   tick_ch ();
    swe_result_if result_ch ();

    safety_watchdog_estop_fsm u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch)
    );

    always #5 clk = ~clk;

    ctl_state_t ctl_now = '0;
    result_t    pending_results [$];
    preset_t    offered_presets [$];
    int         mismatches = 0;

    bit sender_eager   = 1'b0;
    bit receiver_eager = 1'b0;
    bit long_hold_req  = 1'b0;

    // Advance the controller by one tick and return what it reports
    function automatic result_t step_controller(input tick_t t);
        logic [MODE_W-1:0] nxt;
        result_t           r;
        nxt = ctl_now.mode;
        r   = '0;
        case (ctl_now.mode)
            MODE_STARTUP:
            begin
                ctl_now.yellow = 1'b1;
                ctl_now.green  = 1'b0;
                ctl_now.red    = 1'b0;
                ctl_now.light  = BL_ON;
                ctl_now.relay  = 1'b1;
                ctl_now.emerg  = 1'b0;
                nxt            = MODE_LOCAL;
            end
            MODE_LOCAL:
            begin
                if (t.wd_msg_seen)
                begin
                    ctl_now.yellow = 1'b0;
                    ctl_now.green  = 1'b1;
                    nxt            = MODE_REMOTE;
                end
                else if (t.button_pushed)
                begin
                    ctl_now.relay = 1'b0;
                    ctl_now.light = BL_FLASH;
                    ctl_now.emerg = 1'b1;
                    nxt           = MODE_LPUSHED;
                end
            end
            MODE_LPUSHED, MODE_WRELAYOFF, MODE_RRELAYOFF:
            begin
                if (t.button_pushed)
                    nxt = MODE_STARTUP;
            end
            MODE_REMOTE:
            begin
                if (t.wd_msg_seen)
                    nxt = MODE_REMOTE;
                else if (t.wd_expired)
                begin
                    ctl_now.green      = 1'b0;
                    ctl_now.red        = 1'b1;
                    r.start_halt_timer = 1'b1;
                    r.clear_moving     = 1'b1;
                    nxt                = MODE_WSTOP;
                end
                else if (t.button_pushed)
                begin
                    ctl_now.light    = BL_FLASH;
                    ctl_now.emerg    = 1'b1;
                    r.start_pc_timer = 1'b1;
                    nxt              = MODE_PCWAIT;
                end
            end
            MODE_WSTOP, MODE_RSTOP:
            begin
                if (t.trains_running)
                begin
                    ctl_now.relay = 1'b0;
                    ctl_now.light = BL_FAST;
                    nxt = (ctl_now.mode == MODE_WSTOP) ? MODE_WRELAYOFF : MODE_RRELAYOFF;
                end
                else if (t.halt_wait_expired)
                    nxt = (ctl_now.mode == MODE_WSTOP) ? MODE_STARTUP : MODE_RSTOPPED;
            end
            MODE_PCWAIT:
            begin
                if (t.pc_wait_expired)
                begin
                    ctl_now.green      = 1'b0;
                    ctl_now.red        = 1'b1;
                    r.start_halt_timer = 1'b1;
                    r.clear_moving     = 1'b1;
                    nxt                = MODE_RSTOP;
                end
            end
            MODE_RSTOPPED:
            begin
                if (t.button_pushed || t.trains_running)
                    nxt = MODE_STARTUP;
            end
            default:
                nxt = ctl_now.mode;
        endcase
        r.mode_changed   = (nxt != ctl_now.mode);
        ctl_now.mode     = nxt;
        r.mode           = ctl_now.mode;
        r.relay_closed   = ctl_now.relay;
        r.yellow_lamp    = ctl_now.yellow;
        r.green_lamp     = ctl_now.green;
        r.red_lamp       = ctl_now.red;
        r.button_light   = ctl_now.light;
        r.emergency_flag = ctl_now.emerg;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want)
        begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    task automatic compare_result(input result_t want, input result_t got);
        check_field("mode", want.mode, got.mode);
        check_field("relay_closed", 4'(want.relay_closed), 4'(got.relay_closed));
        check_field("yellow_lamp", 4'(want.yellow_lamp), 4'(got.yellow_lamp));
        check_field("green_lamp", 4'(want.green_lamp), 4'(got.green_lamp));
        check_field("red_lamp", 4'(want.red_lamp), 4'(got.red_lamp));
        check_field("button_light", 4'(want.button_light), 4'(got.button_light));
        check_field("emergency_flag", 4'(want.emergency_flag), 4'(got.emergency_flag));
        check_field("start_halt_timer", 4'(want.start_halt_timer),
                    4'(got.start_halt_timer));
        check_field("start_pc_timer", 4'(want.start_pc_timer), 4'(got.start_pc_timer));
        check_field("clear_moving", 4'(want.clear_moving), 4'(got.clear_moving));
        check_field("mode_changed", 4'(want.mode_changed), 4'(got.mode_changed));
    endtask

    // Score result transactions, then queue the expectation of each accepted tick
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $error("result transaction with nothing expected, mode %0d",
                           result_ch.data.mode);
                end
                else
                    compare_result(pending_results.pop_front(), result_ch.data);
            end
            if (tick_ch.valid && tick_ch.ready)
            begin
                preset_t   p;
                result_t   modeled;
                p       = offered_presets.pop_front();
                modeled = step_controller(tick_ch.data);
                pending_results.push_back(p.typed ? p.want : modeled);
            end
        end
    end

    // Offer one tick after a random gap and hold it until accepted
    task automatic offer_tick(input tick_t t, input preset_t p);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (sender_eager || pick < 70)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            @(negedge clk);
            tick_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        offered_presets.push_back(p);
        do @(posedge clk); while (!tick_ch.ready);
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic wait_for_results();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    // Result side: short and long stalls, calm stretches, one long hold-off
    initial
    begin
        int stall_left;
        int pick;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (receiver_eager || pick >= 14)
                    result_ch.ready <= 1'b1;
                else
                begin
                    stall_left = (pick < 12) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                    result_ch.ready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        logic [5:0] bits;
        int         style;
        rst_n           = 1'b0;
        tick_ch.valid   = 1'b0;
        tick_ch.data    = '0;
        result_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            offer_tick(DIRECTED[5'(i)].tk, DIRECTED[5'(i)].preset);
        wait_for_results();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            style          = ph % 3;
            sender_eager   = (ph == 3) || (ph == 6);
            receiver_eager = (ph == 3);
            // Stall results while ticks keep coming so the input backs up
            if (ph == 6)
                long_hold_req = 1'b1;
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                bits = '0;
                case (style)
                    0:
                    begin
                        // at most one event per tick walks the machine cleanly
                        if ($urandom_range(0, 6) != 0)
                            bits[3'($urandom_range(0, 5))] = 1'b1;
                    end
                    1:
                        bits = 6'($urandom_range(0, 63));
                    default:
                    begin
                        for (int b = 0; b < 6; b++)
                            bits[3'(b)] = ($urandom_range(0, 3) == 0);
                    end
                endcase
                offer_tick(tick_t'(bits), NO_PRESET);
            end
            wait_for_results();
        end
        sender_eager   = 1'b0;
        receiver_eager = 1'b0;

        repeat (8) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $error("%0d results never arrived", pending_results.size());
        end
        if (mismatches == 0)
            $display("** safety_watchdog_estop_fsm: PASSED **");
        else
            $display("** safety_watchdog_estop_fsm: FAILED **");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("** safety_watchdog_estop_fsm: FAILED **");
        $finish;
    end

endmodule
